/* design/gcw_pkg.sv */
// Shared types and constants for the grid coordinate wrap / neighbour block.
// No dependencies; imported by gcw_axis_mod and grid_coordinate_wrap_and_neighbor.
`default_nettype none

package gcw_pkg;

  localparam int COORD_W    = 32;
  localparam int OFF_W      = COORD_W + 1;      // coordinate minus bound, or axis width
  localparam int DIV_STEPS  = COORD_W;          // one remainder bit per stage
  // abs stage + remainder stages + sign fix stage + add-bound stage
  localparam int AXIS_LAT   = DIV_STEPS + 3;
  localparam int FIFO_AW    = 6;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_Y = 3'd5;

  typedef enum logic {
    CMD_NORM = 1'b0,
    CMD_NBR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_MINUS_X = 2'd0,
    DIR_PLUS_X  = 2'd1,
    DIR_MINUS_Y = 2'd2,
    DIR_PLUS_Y  = 2'd3
  } dir_t;

  // travels alongside the per-axis remainder pipelines
  typedef struct packed {
    logic       valid;
    cmd_t       cmd;
    dir_t       dir;
    logic       fail;
  } side_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } res_t;

endpackage

`default_nettype wire

/* design/gcw_axis_mod.sv */
// One axis: floor modulo of a signed offset by the axis width, plus the low bound.
// Restoring remainder, one bit per stage. Depends on gcw_pkg.
`default_nettype none

module gcw_axis_mod
  import gcw_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OFF_W-1:0]  off,
  input  logic        [OFF_W-1:0]  wid,
  input  logic        [COORD_W-1:0] lo,
  output logic        [COORD_W-1:0] coord
);

  logic               neg_r [0:DIV_STEPS];
  logic [COORD_W-1:0] mag_r [0:DIV_STEPS-1];
  logic [COORD_W-1:0] rem_r [0:DIV_STEPS];
  logic [COORD_W-1:0] fix_r;
  logic [COORD_W-1:0] coord_r;
  logic [OFF_W-1:0]   neg_off;

  assign neg_off = -off;

  // magnitude fits COORD_W bits: |v - lo| < 2^32
  always_ff @(posedge clk) begin
    neg_r[0] <= off[OFF_W-1];
    mag_r[0] <= off[OFF_W-1] ? neg_off[COORD_W-1:0] : off[COORD_W-1:0];
    rem_r[0] <= '0;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [OFF_W-1:0] t;
    logic [OFF_W-1:0] diff;

    assign t    = {rem_r[k-1], mag_r[k-1][COORD_W-1]};
    assign diff = t - wid;

    always_ff @(posedge clk) begin
      neg_r[k] <= neg_r[k-1];
      rem_r[k] <= (t >= wid) ? diff[COORD_W-1:0] : t[COORD_W-1:0];
    end

    if (k < DIV_STEPS) begin : g_shift
      always_ff @(posedge clk) begin
        mag_r[k] <= {mag_r[k-1][COORD_W-2:0], 1'b0};
      end
    end
  end

  logic [OFF_W-1:0] wrap_back;
  assign wrap_back = wid - {1'b0, rem_r[DIV_STEPS]};

  // negative offset with a non-zero remainder folds back from the top
  always_ff @(posedge clk) begin
    if (neg_r[DIV_STEPS] && (rem_r[DIV_STEPS] != '0)) begin
      fix_r <= wrap_back[COORD_W-1:0];
    end else begin
      fix_r <= rem_r[DIV_STEPS];
    end
    coord_r <= lo + fix_r;
  end

  assign coord = coord_r;

endmodule

`default_nettype wire

/* design/grid_coordinate_wrap_and_neighbor.sv */
// Channel  | Dir | Handshake           | Payload
// in_      | in  | in_valid/in_stall   | in_cmd, in_pos_x, in_pos_y, in_direction
// out_     | out | out_valid/out_stall | out_ok, out_x, out_y
// cfg_     | in  | cfg_we              | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while in_stall is low; each passes through
// the 32-stage remainder pipeline of each axis plus entry, step, queue and output stages.
// The pipeline never stalls; results land in a 64-entry queue and in_stall rises only
// when 64 transactions are accepted but not yet delivered.
// rst_n is synchronous, active low; clears config registers, valid bits, pointers and the count.
// Top level: config registers, bound checks, neighbour step, result queue.
// Depends on gcw_pkg and gcw_axis_mod.
`default_nettype none

module grid_coordinate_wrap_and_neighbor
  import gcw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic [1:0]                in_direction,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_ok,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_wdata
);

  localparam logic [FIFO_AW:0] CREDITS = FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);

  // ---------------- configuration ----------------
  logic signed [COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic                      wrap_x_r, wrap_y_r;
  logic [OFF_W-1:0]          wid_x_r, wid_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r  <= '0;
      max_x_r  <= '0;
      min_y_r  <= '0;
      max_y_r  <= '0;
      wrap_x_r <= 1'b0;
      wrap_y_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X:  min_x_r  <= cfg_wdata;
        REG_MAX_X:  max_x_r  <= cfg_wdata;
        REG_MIN_Y:  min_y_r  <= cfg_wdata;
        REG_MAX_Y:  max_y_r  <= cfg_wdata;
        REG_WRAP_X: wrap_x_r <= cfg_wdata[0];
        REG_WRAP_Y: wrap_y_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // axis widths; only meaningful when min is not above max
  always_ff @(posedge clk) begin
    wid_x_r <= {max_x_r[COORD_W-1], max_x_r} - {min_x_r[COORD_W-1], min_x_r} + OFF_W'(1);
    wid_y_r <= {max_y_r[COORD_W-1], max_y_r} - {min_y_r[COORD_W-1], min_y_r} + OFF_W'(1);
  end

  // ---------------- credit count ----------------
  logic             in_acc, out_acc;
  logic [FIFO_AW:0] cnt_r, cnt_nxt;

  assign in_stall = (cnt_r == CREDITS);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------- entry stage: offsets and bound checks ----------------
  side_t                   a_side_r, a_side_nxt;
  logic signed [OFF_W-1:0] a_offx_r, a_offy_r;
  logic                    fail_x, fail_y;

  always_comb begin
    fail_x = (min_x_r > max_x_r) ||
             (!wrap_x_r && ((in_pos_x < min_x_r) || (in_pos_x > max_x_r)));
    fail_y = (min_y_r > max_y_r) ||
             (!wrap_y_r && ((in_pos_y < min_y_r) || (in_pos_y > max_y_r)));
    a_side_nxt.valid = in_acc;
    a_side_nxt.cmd   = cmd_t'(in_cmd);
    a_side_nxt.dir   = dir_t'(in_direction);
    a_side_nxt.fail  = fail_x || fail_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r <= '0;
    end else begin
      a_side_r <= a_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_offx_r <= {in_pos_x[COORD_W-1], in_pos_x} - {min_x_r[COORD_W-1], min_x_r};
    a_offy_r <= {in_pos_y[COORD_W-1], in_pos_y} - {min_y_r[COORD_W-1], min_y_r};
  end

  // ---------------- per-axis modulo pipelines ----------------
  logic [COORD_W-1:0] cx, cy;

  gcw_axis_mod u_axis_x (
    .clk   (clk),
    .off   (a_offx_r),
    .wid   (wid_x_r),
    .lo    (min_x_r),
    .coord (cx)
  );

  gcw_axis_mod u_axis_y (
    .clk   (clk),
    .off   (a_offy_r),
    .wid   (wid_y_r),
    .lo    (min_y_r),
    .coord (cy)
  );

  side_t side_r [0:AXIS_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AXIS_LAT; k++) begin
        side_r[k] <= '0;
      end
    end else begin
      side_r[0] <= a_side_r;
      for (int k = 1; k < AXIS_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // ---------------- neighbour step ----------------
  side_t side_q;
  res_t  e_nxt, e_r;
  logic  e_valid_r;

  assign side_q = side_r[AXIS_LAT-1];

  always_comb begin
    e_nxt.ok = !side_q.fail;
    e_nxt.x  = cx;
    e_nxt.y  = cy;
    if (side_q.cmd == CMD_NBR) begin
      case (side_q.dir)
        DIR_MINUS_X: begin
          if (cx == min_x_r) begin
            e_nxt.x = max_x_r;
            if (!wrap_x_r) e_nxt.ok = 1'b0;
          end else begin
            e_nxt.x = cx - 1'b1;
          end
        end
        DIR_PLUS_X: begin
          if (cx == max_x_r) begin
            e_nxt.x = min_x_r;
            if (!wrap_x_r) e_nxt.ok = 1'b0;
          end else begin
            e_nxt.x = cx + 1'b1;
          end
        end
        DIR_MINUS_Y: begin
          if (cy == min_y_r) begin
            e_nxt.y = max_y_r;
            if (!wrap_y_r) e_nxt.ok = 1'b0;
          end else begin
            e_nxt.y = cy - 1'b1;
          end
        end
        DIR_PLUS_Y: begin
          if (cy == max_y_r) begin
            e_nxt.y = min_y_r;
            if (!wrap_y_r) e_nxt.ok = 1'b0;
          end else begin
            e_nxt.y = cy + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (!e_nxt.ok) begin
      e_nxt.x = '0;
      e_nxt.y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= side_q.valid;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  // ---------------- result queue and output register ----------------
  res_t             mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW:0] wr_ptr_r, rd_ptr_r;
  logic             q_empty, out_load;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  assign q_empty  = (wr_ptr_r == rd_ptr_r);
  assign out_load = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid_r) begin
      mem[wr_ptr_r[FIFO_AW-1:0]] <= e_r;
    end
    if (out_load) begin
      out_res_r <= mem[rd_ptr_r[FIFO_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (e_valid_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_load) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_res_r.ok;
  assign out_x     = out_res_r.x;
  assign out_y     = out_res_r.y;

`ifndef SYNTHESIS
  logic [FIFO_AW:0] q_fill;
  assign q_fill = wr_ptr_r - rd_ptr_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CREDITS)
    else $error("outstanding transaction count above credit limit");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cnt_r != '0))
    else $error("result presented with no outstanding transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && !e_r.ok) |-> ((e_r.x == '0) && (e_r.y == '0)))
    else $error("failed result carries a non-zero coordinate");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for grid_coordinate_wrap_and_neighbor: directed and random
// coordinate lookups over a range of grid bounds and wrap settings, checked against an
// internal predictor. Depends on gcw_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench
  import gcw_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 105;
  localparam int RAND_PHASES  = 12;
  localparam int SETTLE       = AXIS_LAT + 8;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  // indexes past the register list; writes there must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    dir_t                      dir;
    bit                        drain_first;
  } lookup_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_cmd = 1'b0;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic [1:0]                in_direction = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_ok;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_wdata = '0;

  // shadow of the grid registers as the block should hold them
  logic signed [COORD_W-1:0] grid_min_x = '0, grid_max_x = '0;
  logic signed [COORD_W-1:0] grid_min_y = '0, grid_max_y = '0;
  bit                        grid_wrap_x = 1'b0, grid_wrap_y = 1'b0;

  lookup_t lookup_q[$];
  res_t    expected_q[$];

  bit      noisy = 1'b1;
  int      send_gap = 0;
  int      stall_left = 0;
  int      mismatches = 0;
  int      cycles = 0;
  lookup_t next_lookup;
  res_t    want;

  grid_coordinate_wrap_and_neighbor i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_direction (in_direction),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_x        (out_x),
    .out_y        (out_y),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // floor-modulo wrap of one axis; returns 0 when the value cannot be placed
  function automatic bit bring_into_bounds(inout longint v, input longint lo, input longint hi,
                                           input bit wrap);
    longint width, off;
    if (lo > hi) return 1'b0;
    if (v >= lo && v <= hi) return 1'b1;
    if (!wrap) return 1'b0;
    width = hi - lo + 1;
    off = (v - lo) % width;
    if (off < 0) off += width;
    v = lo + off;
    return 1'b1;
  endfunction

  function automatic res_t grid_lookup(cmd_t cmd, logic signed [COORD_W-1:0] px,
                                       logic signed [COORD_W-1:0] py, dir_t dir);
    longint x, y, lx, hx, ly, hy;
    bit     ok;
    res_t   r;
    x = px;
    y = py;
    lx = grid_min_x;
    hx = grid_max_x;
    ly = grid_min_y;
    hy = grid_max_y;
    ok = bring_into_bounds(x, lx, hx, grid_wrap_x);
    if (ok) ok = bring_into_bounds(y, ly, hy, grid_wrap_y);
    if (ok && cmd == CMD_NBR) begin
      case (dir)
        DIR_MINUS_X: begin
          if (x == lx) begin
            if (grid_wrap_x) x = hx;
            else ok = 1'b0;
          end else x = x - 1;
        end
        DIR_PLUS_X: begin
          if (x == hx) begin
            if (grid_wrap_x) x = lx;
            else ok = 1'b0;
          end else x = x + 1;
        end
        DIR_MINUS_Y: begin
          if (y == ly) begin
            if (grid_wrap_y) y = hy;
            else ok = 1'b0;
          end else y = y - 1;
        end
        default: begin
          if (y == hy) begin
            if (grid_wrap_y) y = ly;
            else ok = 1'b0;
          end else y = y + 1;
        end
      endcase
    end
    r.ok = ok;
    r.x  = ok ? 32'(x) : '0;
    r.y  = ok ? 32'(y) : '0;
    return r;
  endfunction

  // mostly inside or on the edges of the axis, some far away, some extremes
  function automatic logic signed [COORD_W-1:0] pick_coord(longint lo, longint hi);
    int     k;
    longint off;
    k = $urandom_range(0, 9);
    if (lo <= hi && k < 4) begin
      off = {$urandom, $urandom} % (hi - lo + 1);
      return 32'(lo + off);
    end
    if (k < 7) begin
      case ($urandom_range(0, 5))
        0: return 32'(lo - 1);
        1: return 32'(lo);
        2: return 32'(lo + 1);
        3: return 32'(hi - 1);
        4: return 32'(hi);
        default: return 32'(hi + 1);
      endcase
    end
    if (k < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic choose_axis(input int kind, output logic signed [COORD_W-1:0] lo,
                             output logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W-1:0] a, b;
    a = $urandom;
    b = $urandom;
    case (kind)
      0: begin
        lo = int'($urandom_range(0, 100)) - 50;
        hi = lo + int'($urandom_range(0, 15));
      end
      1: begin
        lo = COORD_MIN;
        hi = COORD_MAX;
      end
      2: begin
        lo = COORD_MIN;
        hi = COORD_MIN;
      end
      3: begin
        lo = COORD_MAX;
        hi = COORD_MAX;
      end
      4: begin  // empty axis
        hi = int'($urandom_range(0, 100)) - 50;
        lo = hi + int'($urandom_range(1, 20));
      end
      5: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      6: begin
        if ($urandom_range(0, 1)) begin
          lo = COORD_MIN;
          hi = a;
        end else begin
          lo = a;
          hi = COORD_MAX;
        end
      end
      default: begin
        lo = a;
        hi = a + int'($urandom_range(0, 1000));
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MIN_X:  grid_min_x  = val;
      REG_MAX_X:  grid_max_x  = val;
      REG_MIN_Y:  grid_min_y  = val;
      REG_MAX_Y:  grid_max_y  = val;
      REG_WRAP_X: grid_wrap_x = val[0];
      REG_WRAP_Y: grid_wrap_y = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_grid(input logic signed [COORD_W-1:0] lx, input logic signed [COORD_W-1:0] hx,
                            input logic signed [COORD_W-1:0] ly, input logic signed [COORD_W-1:0] hy,
                            input bit wx, input bit wy);
    logic [COORD_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MAX_Y, hy);
    // upper bits of the wrap flags are don't-care
    write_reg(REG_WRAP_X, {junk[31:1], wx});
    junk = $urandom;
    write_reg(REG_WRAP_Y, {junk[31:1], wy});
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_lookup(input cmd_t cmd, input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py, input dir_t dir,
                              input bit drain_first);
    lookup_t l;
    l.cmd = cmd;
    l.px = px;
    l.py = py;
    l.dir = dir;
    l.drain_first = drain_first;
    lookup_q.push_back(l);
  endtask

  task automatic wait_idle();
    while (lookup_q.size() != 0 || expected_q.size() != 0 || in_valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(grid_lookup(cmd_t'(in_cmd), in_pos_x, in_pos_y,
                                         dir_t'(in_direction)));
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (lookup_q.size() != 0 &&
                     !(lookup_q[0].drain_first && expected_q.size() != 0)) begin
          if (noisy && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
            in_valid <= 1'b0;
          end else begin
            next_lookup = lookup_q.pop_front();
            in_valid     <= 1'b1;
            in_cmd       <= next_lookup.cmd;
            in_pos_x     <= next_lookup.px;
            in_pos_y     <= next_lookup.py;
            in_direction <= next_lookup.dir;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: ok=%0d x=%0d y=%0d",
                     $realtime, out_ok, out_x, out_y);
        end else begin
          want = expected_q.pop_front();
          if (want.ok !== out_ok || want.x !== out_x || want.y !== out_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected ok=%0d x=%0d y=%0d, got ok=%0d x=%0d y=%0d",
                       $realtime, want.ok, $signed(want.x), $signed(want.y),
                       out_ok, out_x, out_y);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (noisy && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    logic signed [COORD_W-1:0] lx, hx, ly, hy;
    bit wx, wy;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid: the single cell (0,0), neither axis wraps
    queue_lookup(CMD_NORM, 0, 0, DIR_PLUS_Y, 1'b0);
    queue_lookup(CMD_NORM, 1, 0, DIR_MINUS_X, 1'b0);
    queue_lookup(CMD_NBR, 0, 0, DIR_PLUS_X, 1'b0);
    wait_idle();

    // small grid, x wraps, y bounded
    apply_grid(-3, 4, 10, 12, 1'b1, 1'b0);
    queue_lookup(CMD_NORM, COORD_MIN, 11, DIR_MINUS_X, 1'b0);
    queue_lookup(CMD_NORM, COORD_MAX, 11, DIR_PLUS_X, 1'b0);
    queue_lookup(CMD_NORM, 0, 13, DIR_MINUS_Y, 1'b0);
    queue_lookup(CMD_NORM, 0, 9, DIR_PLUS_Y, 1'b0);
    queue_lookup(CMD_NORM, -4, 10, DIR_PLUS_Y, 1'b0);
    queue_lookup(CMD_NBR, -3, 11, DIR_MINUS_X, 1'b0);
    queue_lookup(CMD_NBR, 4, 11, DIR_PLUS_X, 1'b0);
    queue_lookup(CMD_NBR, 0, 10, DIR_MINUS_Y, 1'b0);
    queue_lookup(CMD_NBR, 0, 12, DIR_PLUS_Y, 1'b0);
    queue_lookup(CMD_NBR, 0, 11, DIR_MINUS_Y, 1'b1);
    queue_lookup(CMD_NBR, 0, 11, DIR_PLUS_Y, 1'b0);
    queue_lookup(CMD_NBR, 12, 11, DIR_PLUS_X, 1'b0);
    queue_lookup(CMD_NBR, 0, 20, DIR_MINUS_X, 1'b0);
    queue_lookup(CMD_NBR, COORD_MIN, COORD_MAX, DIR_PLUS_X, 1'b0);
    queue_lookup(CMD_NBR, COORD_MAX, 12, DIR_MINUS_Y, 1'b0);
    queue_lookup(CMD_NBR, COORD_MIN, 10, DIR_MINUS_X, 1'b0);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      // first phases sweep every bound shape on both axes, then random ones
      choose_axis(p < 8 ? p : int'($urandom_range(0, 7)), lx, hx);
      choose_axis(p < 8 ? (p + 3) % 8 : int'($urandom_range(0, 7)), ly, hy);
      wx = (p < 4) ? p[0] : $urandom_range(0, 1);
      wy = (p < 4) ? p[1] : $urandom_range(0, 1);
      apply_grid(lx, hx, ly, hy, wx, wy);
      noisy = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_lookup($urandom_range(0, 9) < 6 ? CMD_NBR : CMD_NORM,
                     pick_coord(grid_min_x, grid_max_x), pick_coord(grid_min_y, grid_max_y),
                     dir_t'($urandom_range(0, 3)), i == PHASE_ITEMS / 2);
      wait_idle();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
